// ===== sv/jpral_pkg.sv =====
// Shared types and constants for the joint position, rate and acceleration limiter.
// No dependencies; imported by the state memory and the top level.
package jpral_pkg;

  // Fixed field widths
  localparam int JIDX_W    = 4;
  localparam int STEP_W    = 31;
  localparam int EN_W      = 4;
  localparam int CFG_IDX_W = 3;
  localparam int HIST_W    = 2;

  // Per-joint history depth: frames seen in the current track, saturating
  localparam logic [HIST_W-1:0] HIST_NONE = 2'd0;
  localparam logic [HIST_W-1:0] HIST_ONE  = 2'd1;
  localparam logic [HIST_W-1:0] HIST_FULL = 2'd2;

  // Bit positions in limit_enable
  localparam int EN_MIN   = 0;
  localparam int EN_MAX   = 1;
  localparam int EN_VEL   = 2;
  localparam int EN_ACCEL = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_POSITION    = 3'd0,
    REG_MAX_POSITION    = 3'd1,
    REG_MAX_STEP        = 3'd2,
    REG_MAX_STEP_CHANGE = 3'd3,
    REG_LIMIT_ENABLE    = 3'd4
  } cfg_reg_t;

  // Read request from the pipeline front end to the state memory
  typedef struct packed {
    logic en;        // capture read data and history (pipeline advances)
    logic accept;    // a sample is taken this cycle: update its history count
    logic first;     // sample starts a new track
    logic in_range;  // joint index below JOINTS
  } mem_rd_t;

endpackage

// ===== sv/joint_position_rate_accel_limiter_top.sv =====
// Top level of the joint position, rate and acceleration limiter: pipeline,
// configuration registers and hazard interlock. Depends on jpral_pkg,
// jpral_state_mem, jpral_bound and jpral_clamp.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+-----------
//  in      | in_valid, in_stall, joint_index,          | request in
//          | position_in, first_frame                  |
//  out     | out_valid, out_stall, joint_out,          | request out
//          | position_out, position_clamped,           |
//          | velocity_limited, accel_limited           |
//  cfg     | cfg_write, cfg_index, cfg_data            | write only
//
// One request per cycle unless out_stall or the interlock holds the input.
// A request for a joint that still has a request in flight (up to four stages)
// waits until that one writes back its state entry at the output register load.
// The per-joint state memory is read at acceptance and written at the tail.
// Reset (rst, synchronous) clears valids and history counts and restores the
// configuration defaults; no clearing pass over the state memory is needed.
// out_stall holds the whole pipeline and the memory read register.
module joint_position_rate_accel_limiter_top #(
  parameter int JOINTS    = 14,
  parameter int POS_WIDTH = 32,
  localparam int CFG_W    = (POS_WIDTH > 31) ? POS_WIDTH : 31
) (
  input  logic                              clk,
  input  logic                              rst,
  // input request
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [jpral_pkg::JIDX_W-1:0]      joint_index,
  input  logic signed [POS_WIDTH-1:0]       position_in,
  input  logic                              first_frame,
  // result request
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [jpral_pkg::JIDX_W-1:0]      joint_out,
  output logic signed [POS_WIDTH-1:0]       position_out,
  output logic                              position_clamped,
  output logic                              velocity_limited,
  output logic                              accel_limited,
  // configuration
  input  logic                              cfg_write,
  input  logic [jpral_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]                  cfg_data
);
  import jpral_pkg::*;

  // Exact arithmetic width for window ends: 2*p - pp +/- step never overflows
  localparam int BASE_W = (POS_WIDTH > STEP_W + 1) ? POS_WIDTH : STEP_W + 1;
  localparam int EW     = BASE_W + 3;
  localparam int AW     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int JX_W   = JIDX_W + AW;
  localparam logic [JX_W-1:0] JOINTS_X = JX_W'(JOINTS);
  localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] POS_MIN = ~POS_MAX;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [POS_WIDTH-1:0] pos_floor;
  logic signed [POS_WIDTH-1:0] pos_ceiling;
  logic [STEP_W-1:0]           max_step;
  logic [STEP_W-1:0]           max_step_change;
  logic [EN_W-1:0]             limit_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_floor       <= POS_MIN;
      pos_ceiling     <= POS_MAX;
      max_step        <= '1;
      max_step_change <= '1;
      limit_enable    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_POSITION:    pos_floor       <= cfg_data[POS_WIDTH-1:0];
        REG_MAX_POSITION:    pos_ceiling     <= cfg_data[POS_WIDTH-1:0];
        REG_MAX_STEP:        max_step        <= cfg_data[STEP_W-1:0];
        REG_MAX_STEP_CHANGE: max_step_change <= cfg_data[STEP_W-1:0];
        REG_LIMIT_ENABLE:    limit_enable    <= cfg_data[EN_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  logic en_min;
  logic en_max;
  assign en_min = limit_enable[EN_MIN];
  assign en_max = limit_enable[EN_MAX];

  // ---------------------------------------------------------------------------
  // Handshake and hazard interlock
  // ---------------------------------------------------------------------------
  logic advance;
  logic accept;
  logic hazard;
  logic in_range;
  logic [JX_W-1:0] jx;
  logic [AW-1:0]   raddr;

  logic                        s0_valid, s1_valid, s2_valid, s3_valid;
  logic [JIDX_W-1:0]           s0_joint, s1_joint, s2_joint, s3_joint;
  logic                        s0_in_range, s1_in_range, s2_in_range, s3_in_range;

  assign jx       = {{AW{1'b0}}, joint_index};
  assign raddr    = jx[AW-1:0];
  assign in_range = jx < JOINTS_X;

  // Advance whenever the output register is free or being emptied
  assign advance = !out_valid || !out_stall;

  // Hold a request whose joint still has an unwritten state entry in flight
  assign hazard = in_range && (
      (s0_valid && s0_in_range && (s0_joint == joint_index)) ||
      (s1_valid && s1_in_range && (s1_joint == joint_index)) ||
      (s2_valid && s2_in_range && (s2_joint == joint_index)) ||
      (s3_valid && s3_in_range && (s3_joint == joint_index)));

  assign in_stall = !advance || hazard;
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Position clamp at acceptance
  // ---------------------------------------------------------------------------
  logic signed [POS_WIDTH-1:0] v_min;
  logic signed [POS_WIDTH-1:0] v_clamp;

  always_comb begin
    v_min   = (en_min && (position_in < pos_floor)) ? pos_floor : position_in;
    v_clamp = (en_max && (v_min > pos_ceiling)) ? pos_ceiling : v_min;
  end

  // ---------------------------------------------------------------------------
  // State memory
  // ---------------------------------------------------------------------------
  mem_rd_t                rd;
  logic                   mem_we;
  logic [AW-1:0]          waddr;
  logic [3*POS_WIDTH-1:0] wdata;
  logic [3*POS_WIDTH-1:0] rdata;
  logic [HIST_W-1:0]      s0_hist;

  assign rd.en       = advance;
  assign rd.accept   = accept;
  assign rd.first    = first_frame;
  assign rd.in_range = in_range;

  jpral_state_mem #(
    .JOINTS    (JOINTS),
    .POS_WIDTH (POS_WIDTH),
    .AW        (AW)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .raddr   (raddr),
    .we      (mem_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .rdata   (rdata),
    .hist_rd (s0_hist)
  );

  // Entry layout: {velocity_stage_prev, final_prev, final_prev2}
  logic signed [POS_WIDTH-1:0] s0_vprev;
  logic signed [POS_WIDTH-1:0] s0_fp;
  logic signed [POS_WIDTH-1:0] s0_fpp;
  logic signed [EW-1:0]        s0_vprev_x;
  logic signed [EW-1:0]        s0_fp_x;
  logic signed [EW-1:0]        s0_fpp_x;
  logic signed [EW-1:0]        step_x;
  logic signed [EW-1:0]        step_chg_x;

  assign s0_vprev   = rdata[3*POS_WIDTH-1:2*POS_WIDTH];
  assign s0_fp      = rdata[2*POS_WIDTH-1:POS_WIDTH];
  assign s0_fpp     = rdata[POS_WIDTH-1:0];
  assign s0_vprev_x = {{(EW-POS_WIDTH){s0_vprev[POS_WIDTH-1]}}, s0_vprev};
  assign s0_fp_x    = {{(EW-POS_WIDTH){s0_fp[POS_WIDTH-1]}}, s0_fp};
  assign s0_fpp_x   = {{(EW-POS_WIDTH){s0_fpp[POS_WIDTH-1]}}, s0_fpp};
  assign step_x     = {{(EW-STEP_W){1'b0}}, max_step};
  assign step_chg_x = {{(EW-STEP_W){1'b0}}, max_step_change};

  // ---------------------------------------------------------------------------
  // Stage 0: request registers (memory data arrives alongside)
  // ---------------------------------------------------------------------------
  logic signed [POS_WIDTH-1:0] s0_v;
  logic                        s0_pc;

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_joint    <= joint_index;
      s0_in_range <= in_range;
      s0_v        <= v_clamp;
      s0_pc       <= (v_clamp != position_in);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: exact velocity window ends and acceleration center
  // ---------------------------------------------------------------------------
  logic signed [POS_WIDTH-1:0] s1_v;
  logic                        s1_pc;
  logic [HIST_W-1:0]           s1_hist;
  logic signed [POS_WIDTH-1:0] s1_fp;
  logic signed [EW-1:0]        s1_vlo_x;
  logic signed [EW-1:0]        s1_vhi_x;
  logic signed [EW-1:0]        s1_center;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_joint    <= s0_joint;
      s1_in_range <= s0_in_range;
      s1_v        <= s0_v;
      s1_pc       <= s0_pc;
      s1_hist     <= s0_hist;
      s1_fp       <= s0_fp;
      s1_vlo_x    <= s0_vprev_x - step_x;
      s1_vhi_x    <= s0_vprev_x + step_x;
      s1_center   <= {s0_fp_x[EW-2:0], 1'b0} - s0_fpp_x;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: saturated velocity window, exact acceleration window
  // ---------------------------------------------------------------------------
  logic signed [POS_WIDTH-1:0] vel_lo, vel_hi, vel_blo, vel_bhi;

  jpral_bound #(
    .POS_WIDTH (POS_WIDTH),
    .EW        (EW)
  ) u_vel_bound (
    .lo_x    (s1_vlo_x),
    .hi_x    (s1_vhi_x),
    .min_pos (pos_floor),
    .max_pos (pos_ceiling),
    .en_min  (en_min),
    .en_max  (en_max),
    .lo      (vel_lo),
    .hi      (vel_hi),
    .blo     (vel_blo),
    .bhi     (vel_bhi)
  );

  logic signed [POS_WIDTH-1:0] s2_v;
  logic                        s2_pc;
  logic [HIST_W-1:0]           s2_hist;
  logic signed [POS_WIDTH-1:0] s2_fp;
  logic signed [POS_WIDTH-1:0] s2_vlo, s2_vhi, s2_vblo, s2_vbhi;
  logic signed [EW-1:0]        s2_alo_x;
  logic signed [EW-1:0]        s2_ahi_x;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_joint    <= s1_joint;
      s2_in_range <= s1_in_range;
      s2_v        <= s1_v;
      s2_pc       <= s1_pc;
      s2_hist     <= s1_hist;
      s2_fp       <= s1_fp;
      s2_vlo      <= vel_lo;
      s2_vhi      <= vel_hi;
      s2_vblo     <= vel_blo;
      s2_vbhi     <= vel_bhi;
      s2_alo_x    <= s1_center - step_chg_x;
      s2_ahi_x    <= s1_center + step_chg_x;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: velocity clamp, saturated acceleration window
  // ---------------------------------------------------------------------------
  logic signed [POS_WIDTH-1:0] vel_r;
  logic                        vel_act;
  logic signed [POS_WIDTH-1:0] acc_lo, acc_hi, acc_blo, acc_bhi;

  jpral_clamp #(
    .POS_WIDTH (POS_WIDTH)
  ) u_vel_clamp (
    .v       (s2_v),
    .lo      (s2_vlo),
    .hi      (s2_vhi),
    .blo     (s2_vblo),
    .bhi     (s2_vbhi),
    .min_pos (pos_floor),
    .max_pos (pos_ceiling),
    .en_min  (en_min),
    .en_max  (en_max),
    .r       (vel_r)
  );

  jpral_bound #(
    .POS_WIDTH (POS_WIDTH),
    .EW        (EW)
  ) u_acc_bound (
    .lo_x    (s2_alo_x),
    .hi_x    (s2_ahi_x),
    .min_pos (pos_floor),
    .max_pos (pos_ceiling),
    .en_min  (en_min),
    .en_max  (en_max),
    .lo      (acc_lo),
    .hi      (acc_hi),
    .blo     (acc_blo),
    .bhi     (acc_bhi)
  );

  // Velocity stage runs from the second frame of a track on
  assign vel_act = (s2_hist != HIST_NONE) && limit_enable[EN_VEL];

  logic signed [POS_WIDTH-1:0] s3_vs;
  logic                        s3_pc;
  logic                        s3_vl;
  logic [HIST_W-1:0]           s3_hist;
  logic signed [POS_WIDTH-1:0] s3_fp;
  logic signed [POS_WIDTH-1:0] s3_alo, s3_ahi, s3_ablo, s3_abhi;
  logic signed [EW-1:0]        s3_alo_x;
  logic signed [EW-1:0]        s3_ahi_x;

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_joint    <= s2_joint;
      s3_in_range <= s2_in_range;
      s3_vs       <= vel_act ? vel_r : s2_v;
      s3_vl       <= vel_act && (vel_r != s2_v);
      s3_pc       <= s2_pc;
      s3_hist     <= s2_hist;
      s3_fp       <= s2_fp;
      s3_alo      <= acc_lo;
      s3_ahi      <= acc_hi;
      s3_ablo     <= acc_blo;
      s3_abhi     <= acc_bhi;
      s3_alo_x    <= s2_alo_x;
      s3_ahi_x    <= s2_ahi_x;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: acceleration clamp, write-back and output register
  // ---------------------------------------------------------------------------
  logic signed [POS_WIDTH-1:0] acc_r;
  logic                        acc_act;
  logic signed [EW-1:0]        s3_vs_x;
  logic signed [POS_WIDTH-1:0] final_pos;
  logic                        acc_out;
  logic [JX_W-1:0]             s3_jx;

  jpral_clamp #(
    .POS_WIDTH (POS_WIDTH)
  ) u_acc_clamp (
    .v       (s3_vs),
    .lo      (s3_alo),
    .hi      (s3_ahi),
    .blo     (s3_ablo),
    .bhi     (s3_abhi),
    .min_pos (pos_floor),
    .max_pos (pos_ceiling),
    .en_min  (en_min),
    .en_max  (en_max),
    .r       (acc_r)
  );

  // Acceleration stage needs two earlier finals in the current track
  assign acc_act   = (s3_hist == HIST_FULL) && limit_enable[EN_ACCEL];
  assign s3_vs_x   = {{(EW-POS_WIDTH){s3_vs[POS_WIDTH-1]}}, s3_vs};
  assign final_pos = acc_act ? acc_r : s3_vs;
  assign acc_out   = acc_act && ((s3_vs_x < s3_alo_x) || (s3_vs_x > s3_ahi_x));

  // Write back: shift final history and store the velocity-stage output
  assign mem_we = advance && s3_valid && s3_in_range;
  assign s3_jx  = {{AW{1'b0}}, s3_joint};
  assign waddr  = s3_jx[AW-1:0];
  assign wdata  = {s3_vs, final_pos, s3_fp};

  always_ff @(posedge clk) begin
    if (advance) begin
      joint_out        <= s3_joint;
      position_out     <= final_pos;
      position_clamped <= s3_pc;
      velocity_limited <= s3_vl;
      accel_limited    <= acc_out;
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s0_valid  <= accept;
      s1_valid  <= s0_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

endmodule

// ===== sv/jpral_state_mem.sv =====
// Per-joint state memory: previous velocity-stage output and last two final outputs,
// plus the history counts in flip-flops. Depends on jpral_pkg.
module jpral_state_mem #(
  parameter int JOINTS    = 14,
  parameter int POS_WIDTH = 32,
  parameter int AW        = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  jpral_pkg::mem_rd_t        rd,
  input  logic [AW-1:0]             raddr,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [3*POS_WIDTH-1:0]    wdata,
  output logic [3*POS_WIDTH-1:0]    rdata,
  output logic [jpral_pkg::HIST_W-1:0] hist_rd
);
  import jpral_pkg::*;

  logic [3*POS_WIDTH-1:0] mem [JOINTS];
  logic [HIST_W-1:0]      hist [JOINTS];
  logic [HIST_W-1:0]      hist_cur;
  logic [HIST_W-1:0]      hist_next;

  assign hist_cur = rd.in_range ? hist[raddr] : HIST_NONE;

  always_comb begin
    if (rd.first) begin
      hist_next = HIST_ONE;
    end else if (hist_cur == HIST_FULL) begin
      hist_next = HIST_FULL;
    end else begin
      hist_next = hist_cur + HIST_ONE;
    end
  end

  // Synchronous read, registered while rd.en is set; write-back from the pipeline tail
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINTS; i++) begin
        hist[i] <= HIST_NONE;
      end
      hist_rd <= HIST_NONE;
    end else begin
      if (rd.accept && rd.in_range) begin
        hist[raddr] <= hist_next;
      end
      if (rd.en) begin
        hist_rd <= rd.first ? HIST_NONE : hist_cur;
      end
    end
  end

endmodule

// ===== sv/jpral_bound.sv =====
// Window ends: saturate exact window ends to the position range and intersect
// them with the enabled position bounds. No package dependency.
module jpral_bound #(
  parameter int POS_WIDTH = 32,
  parameter int EW        = 35
) (
  input  logic signed [EW-1:0]        lo_x,
  input  logic signed [EW-1:0]        hi_x,
  input  logic signed [POS_WIDTH-1:0] min_pos,
  input  logic signed [POS_WIDTH-1:0] max_pos,
  input  logic                        en_min,
  input  logic                        en_max,
  output logic signed [POS_WIDTH-1:0] lo,
  output logic signed [POS_WIDTH-1:0] hi,
  output logic signed [POS_WIDTH-1:0] blo,
  output logic signed [POS_WIDTH-1:0] bhi
);

  localparam logic signed [EW-1:0] SAT_HI =
    {{(EW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

  always_comb begin
    if (lo_x > SAT_HI) begin
      lo = SAT_HI[POS_WIDTH-1:0];
    end else if (lo_x < SAT_LO) begin
      lo = SAT_LO[POS_WIDTH-1:0];
    end else begin
      lo = lo_x[POS_WIDTH-1:0];
    end
    if (hi_x > SAT_HI) begin
      hi = SAT_HI[POS_WIDTH-1:0];
    end else if (hi_x < SAT_LO) begin
      hi = SAT_LO[POS_WIDTH-1:0];
    end else begin
      hi = hi_x[POS_WIDTH-1:0];
    end
    blo = (en_min && (min_pos > lo)) ? min_pos : lo;
    bhi = (en_max && (max_pos < hi)) ? max_pos : hi;
  end

endmodule

// ===== sv/jpral_clamp.sv =====
// Window clamp: clamp a sample to the intersected window, or, when the window
// and the position bounds miss each other, to the window and then the bounds.
module jpral_clamp #(
  parameter int POS_WIDTH = 32
) (
  input  logic signed [POS_WIDTH-1:0] v,
  input  logic signed [POS_WIDTH-1:0] lo,
  input  logic signed [POS_WIDTH-1:0] hi,
  input  logic signed [POS_WIDTH-1:0] blo,
  input  logic signed [POS_WIDTH-1:0] bhi,
  input  logic signed [POS_WIDTH-1:0] min_pos,
  input  logic signed [POS_WIDTH-1:0] max_pos,
  input  logic                        en_min,
  input  logic                        en_max,
  output logic signed [POS_WIDTH-1:0] r
);

  logic signed [POS_WIDTH-1:0] t;

  always_comb begin
    t = v;
    if (blo <= bhi) begin
      if (v < blo) begin
        r = blo;
      end else if (v > bhi) begin
        r = bhi;
      end else begin
        r = v;
      end
    end else begin
      // bounds win: window first, then min, then max
      if (v < lo) begin
        t = lo;
      end else if (v > hi) begin
        t = hi;
      end
      if (en_min && (t < min_pos)) begin
        t = min_pos;
      end
      if (en_max && (t > max_pos)) begin
        t = max_pos;
      end
      r = t;
    end
  end

endmodule
